// File: rtl/core/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types and constants of the k-way merge selector: field widths,
// command and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

  // Port widths of the item fields
  localparam int SORT_KEY_W = 64;
  localparam int TAG_W      = 32;
  localparam int RUN_W      = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUNS_IN_USE = 2'd1;

  localparam logic [CFG_DATA_W-1:0] RUNS_IN_USE_RESET = 4'd8;

  // Input commands
  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_EXHAUST = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FLUSH,
    ST_FIN
  } kms_state_t;

endpackage

`default_nettype wire

// File: rtl/core/kms_ram.sv
// ----------------------------------------------------------------------------
// kms_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kms_cmp.sv
// ----------------------------------------------------------------------------
// kms_cmp
// Shared key comparator of the merge scan. Decides whether the candidate
// head replaces the best head found so far in the current scan.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_cmp #(
  parameter int KEY_BITS = 64
) (
  input  wire logic                descending,
  input  wire logic                cand_valid,
  input  wire logic [KEY_BITS-1:0] cand_key,
  input  wire logic                best_found,
  input  wire logic [KEY_BITS-1:0] best_key,
  output logic                     take
);

  logic better;

  // strict compare: on a tie the earlier (lower) run stays selected
  always_comb begin
    if (descending) begin
      better = cand_key > best_key;
    end else begin
      better = cand_key < best_key;
    end
    take = cand_valid && (!best_found || better);
  end

endmodule

`default_nettype wire

// File: rtl/core/kway_merge_selector.sv
// ----------------------------------------------------------------------------
// kway_merge_selector
// Merge stage of an external sort: holds one head record per run and
// emits the next record in merge order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): each transaction either pushes a run's
//   next head record (command push) or marks the run exhausted. in_stall is
//   high while the block works on a transaction.
//   Output channel (out_valid/out_stall): at most one record per input
//   transaction, once every run in use holds a head or is exhausted. The
//   record with the smallest key (largest when descending) goes out, lowest
//   run first on a tie, with the run to refill and a final-record flag.
//   Config channel (cfg_valid/cfg_ready): always ready; write only when idle.
//   Sequence: an item goes through the accept in idle, a readiness check,
//   one head-RAM read per run in use through the single key comparator,
//   a flush state and a finish state. A transaction that yields no record
//   returns to idle after the readiness check.
//   Stall: a finished record waits in the output register; the next input
//   is accepted meanwhile, but its result waits for that register to empty.
//   Reset (rst, synchronous) clears all head-valid and exhausted flags and
//   returns descending to 0 and runs_in_use to 8. No RAM clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_merge_selector
  import kms_pkg::*;
#(
  parameter int RUNS     = 8,
  parameter int KEY_BITS = 64,
  parameter int TAG_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  command,
  input  wire logic [RUN_W-1:0]      run_index,
  input  wire logic [SORT_KEY_W-1:0] sort_key,
  input  wire logic [TAG_W-1:0]      record_tag,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [SORT_KEY_W-1:0] out_key,
  output logic      [TAG_W-1:0]      out_tag,
  output logic      [RUN_W-1:0]      out_run,
  output logic                       final_record,
  // configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(RUNS);
  localparam int CNT_W = $clog2(RUNS + 1);
  localparam int ENT_W = KEY_BITS + TAG_BITS;

  kms_state_t state, state_next;

  // configuration registers
  logic                  descending;
  logic [CFG_DATA_W-1:0] runs_in_use;

  // per-run flags
  logic [RUNS-1:0] head_valid, head_valid_next;
  logic [RUNS-1:0] run_done, run_done_next;

  // scan registers
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_pend;
  logic                best_found;
  logic [IDX_W-1:0]    best_idx;
  logic [KEY_BITS-1:0] best_key;
  logic [TAG_BITS-1:0] best_tag;

  logic [CNT_W-1:0] live_n;
  logic [RUNS-1:0]  live;
  logic [RUNS-1:0]  best_sel;
  logic             in_acc;
  logic             in_use;
  logic [IDX_W-1:0] widx;
  logic             all_ready;
  logic             any_held;
  logic             scan_last;
  logic             fin_go;
  logic             last;
  logic             take;
  logic             ram_we;
  logic             ram_re;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      descending  <= 1'b0;
      runs_in_use <= RUNS_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DESCENDING:  descending  <= cfg_data[0];
        REG_RUNS_IN_USE: runs_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective run count, clamped to 1..RUNS
  always_comb begin
    if (runs_in_use == '0) begin
      live_n = CNT_W'(1);
    end else if (32'(runs_in_use) > 32'(RUNS)) begin
      live_n = CNT_W'(RUNS);
    end else begin
      live_n = CNT_W'(runs_in_use);
    end
  end

  // live-run mask and one-hot of the selected run
  always_comb begin
    for (int i = 0; i < RUNS; i++) begin
      live[i]     = CNT_W'(i) < live_n;
      best_sel[i] = IDX_W'(i) == best_idx;
    end
  end

  assign in_use    = 32'(run_index) < 32'(live_n);
  assign widx      = IDX_W'(run_index);
  assign all_ready = &(~live | head_valid | run_done);
  assign any_held  = |(live & head_valid);
  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == live_n;
  assign fin_go    = !out_valid || !out_stall;
  assign last      = ~|(live & ~best_sel & (head_valid | ~run_done));

  // head record store
  assign ram_we    = in_acc && in_use && (command == CMD_PUSH);
  assign ram_wdata = {TAG_BITS'(record_tag), sort_key[KEY_BITS-1:0]};
  assign ram_re    = (state == ST_SCAN);

  kms_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RUNS)
  ) u_head_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // shared comparator
  kms_cmp #(
    .KEY_BITS (KEY_BITS)
  ) u_cmp (
    .descending (descending),
    .cand_valid (rd_pend && head_valid[rd_idx]),
    .cand_key   (ram_rdata[KEY_BITS-1:0]),
    .best_found (best_found),
    .best_key   (best_key),
    .take       (take)
  );

  // flag updates: accepted transaction, and release of the emitted head
  always_comb begin
    head_valid_next = head_valid;
    run_done_next   = run_done;
    if (in_acc && in_use) begin
      if (command == CMD_PUSH) begin
        head_valid_next[widx] = 1'b1;
        run_done_next[widx]   = 1'b0;
      end else begin
        run_done_next[widx]   = 1'b1;
      end
    end
    if (state == ST_FIN && fin_go) begin
      head_valid_next[best_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      run_done   <= '0;
    end else begin
      head_valid <= head_valid_next;
      run_done   <= run_done_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (all_ready && any_held) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan counters and best-so-far tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
      scan_idx   <= '0;
    end else begin
      rd_pend <= (state == ST_SCAN);
      if (state == ST_CHECK) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else if (state == ST_SCAN && !scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (take) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (take) begin
      best_idx <= rd_idx;
      best_key <= ram_rdata[KEY_BITS-1:0];
      best_tag <= ram_rdata[ENT_W-1:KEY_BITS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && fin_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && fin_go) begin
      out_key      <= SORT_KEY_W'(best_key);
      out_tag      <= TAG_W'(best_tag);
      out_run      <= RUN_W'(best_idx);
      final_record <= last;
    end
  end

endmodule

`default_nettype wire

// File: verif/kway_merge_selector_tb.sv
// ----------------------------------------------------------------------------
// kway_merge_selector_tb
// Self-checking bench for the k-way merge selector. A behavioral model of
// the run heads predicts every merged record as input transactions are
// accepted; a monitor compares each output transaction field by field.
// Directed merges cover ties, overwrites, exhausted runs, reopened runs,
// runs outside use and the run count limits; random merges follow the
// feeder protocol with some noise mixed in, under random bursts, gaps,
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module kway_merge_selector_tb
  import kms_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_COUNT     = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [SORT_KEY_W-1:0] key;
    logic [TAG_W-1:0]      tag;
    logic [RUN_W-1:0]      run;
    logic                  last;
  } merge_rec_t;

  // DUT signals; the driven inputs are known from time zero
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  command      = CMD_PUSH;
  logic [RUN_W-1:0]      run_index    = '0;
  logic [SORT_KEY_W-1:0] sort_key     = '0;
  logic [TAG_W-1:0]      record_tag   = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [SORT_KEY_W-1:0] out_key;
  logic [TAG_W-1:0]      out_tag;
  logic [RUN_W-1:0]      out_run;
  logic                  final_record;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_DESCENDING;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Model of the run heads and the configuration
  logic [SORT_KEY_W-1:0] head_key_m [RUN_COUNT];
  logic [TAG_W-1:0]      head_tag_m [RUN_COUNT];
  bit                    head_held  [RUN_COUNT];
  bit                    run_closed [RUN_COUNT];
  logic                  cfg_desc = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_runs = RUNS_IN_USE_RESET;

  merge_rec_t expected_records[$];
  merge_rec_t got;
  int         mismatches  = 0;
  int         cycle_count = 0;

  // Sender pacing
  int burst_left = 0;
  int gap_max    = 0;
  bit offering   = 1'b0;

  // Receiver pacing
  int stall_pct  = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left  = 0;
  int seg_left   = 0;
  bit seg_stall  = 1'b0;

  kway_merge_selector i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .run_index    (run_index),
    .sort_key     (sort_key),
    .record_tag   (record_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key      (out_key),
    .out_tag      (out_tag),
    .out_run      (out_run),
    .final_record (final_record),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Run-time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: long hold-off on request, otherwise stall segments
  always @(posedge clk) begin
    if (hold_given != hold_asked) begin
      hold_given = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_stall = ($urandom_range(99) < stall_pct);
        seg_left  = $urandom_range(1, 6);
      end
      seg_left--;
      out_stall <= seg_stall;
    end
  end

  function automatic void log_failure(string what);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] %s", $realtime, what);
  endfunction

  // Monitor: each output transaction against the oldest expected record
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        log_failure($sformatf("unexpected record key=%h tag=%h run=%0d final=%0b",
                              out_key, out_tag, out_run, final_record));
      end else begin
        got = expected_records.pop_front();
        if (out_key !== got.key || out_tag !== got.tag || out_run !== got.run ||
            final_record !== got.last)
          log_failure($sformatf({"record mismatch: exp key=%h tag=%h run=%0d final=%0b",
                                 " got key=%h tag=%h run=%0d final=%0b"},
                                got.key, got.tag, got.run, got.last,
                                out_key, out_tag, out_run, final_record));
      end
    end
  end

  function automatic int active_runs();
    if (cfg_runs == 0) return 1;
    if (cfg_runs > RUN_COUNT) return RUN_COUNT;
    return int'(cfg_runs);
  endfunction

  // Apply one accepted transaction to the model; queue the record it releases
  function automatic void merge_select_step(logic c, logic [RUN_W-1:0] r,
                                            logic [SORT_KEY_W-1:0] k, logic [TAG_W-1:0] t);
    int n;
    int pick;
    int i;
    bit blocked;
    merge_rec_t rec;
    n = active_runs();
    pick = -1;
    blocked = 1'b0;
    if (int'(r) < n) begin
      if (c == CMD_PUSH) begin
        head_key_m[r] = k;
        head_tag_m[r] = t;
        head_held[r]  = 1'b1;
        run_closed[r] = 1'b0;
      end else begin
        run_closed[r] = 1'b1;
      end
    end
    // every run in use must hold a head or be exhausted
    for (i = 0; i < n; i++)
      if (!head_held[i] && !run_closed[i]) blocked = 1'b1;
    if (blocked) return;
    // strict compare keeps the lowest run on a tie
    for (i = 0; i < n; i++) begin
      if (head_held[i]) begin
        if (pick < 0) pick = i;
        else if (cfg_desc ? (head_key_m[i] > head_key_m[pick])
                          : (head_key_m[i] < head_key_m[pick])) pick = i;
      end
    end
    if (pick < 0) return;
    head_held[pick] = 1'b0;
    rec.key  = head_key_m[pick];
    rec.tag  = head_tag_m[pick];
    rec.run  = pick[RUN_W-1:0];
    rec.last = 1'b1;
    for (i = 0; i < n; i++)
      if (i != pick && (head_held[i] || !run_closed[i])) rec.last = 1'b0;
    expected_records.push_back(rec);
  endfunction

  // One input transaction, with burst/gap pacing
  task automatic send_item(logic c, logic [RUN_W-1:0] r,
                           logic [SORT_KEY_W-1:0] k, logic [TAG_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        if (offering) in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    offering   = 1'b1;
    command    <= c;
    run_index  <= r;
    sort_key   <= k;
    record_tag <= t;
    do @(posedge clk); while (in_stall);
    merge_select_step(c, r, k, t);
  endtask

  // Stop offering, drain expected records, let a silent transaction finish
  task automatic settle();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic desc, logic [CFG_DATA_W-1:0] runs);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DESCENDING;
    cfg_data  <= CFG_DATA_W'(desc);
    do @(posedge clk); while (!cfg_ready);
    cfg_desc = desc;
    cfg_index <= REG_RUNS_IN_USE;
    cfg_data  <= runs;
    do @(posedge clk); while (!cfg_ready);
    cfg_runs = runs;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SORT_KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0:       return {$urandom, $urandom};
      1:       return SORT_KEY_W'($urandom_range(0, 15));     // many ties
      2:       return {SORT_KEY_W{1'($urandom_range(1))}};    // extremes
      default: return {30'd0, 2'($urandom_range(3)), $urandom};
    endcase
  endfunction

  // Mostly feeder behavior: refill a run the merge waits on, now and then
  // exhaust it; the rest is noise on any run index
  task automatic random_item();
    int n;
    int i;
    int waiting[$];
    logic c;
    logic [RUN_W-1:0] r;
    n = active_runs();
    if ($urandom_range(99) < 80) begin
      for (i = 0; i < n; i++)
        if (!head_held[i] && !run_closed[i]) waiting.push_back(i);
      if (waiting.size() > 0) begin
        r = RUN_W'(waiting[$urandom_range(waiting.size() - 1)]);
        c = ($urandom_range(99) < 12) ? CMD_EXHAUST : CMD_PUSH;
      end else begin
        // merge finished or stuck on held heads: start over on some run
        r = RUN_W'($urandom_range(n - 1));
        c = CMD_PUSH;
      end
    end else begin
      r = RUN_W'($urandom_range(RUN_COUNT - 1));
      c = $urandom_range(1) ? CMD_EXHAUST : CMD_PUSH;
    end
    send_item(c, r, pick_key(), $urandom);
  endtask

  // Ascending merge over three runs: tie, overwrite, outside run, exhaust
  // with a held head, empty finish, reopen
  task automatic test_ascending_merge();
    write_config(1'b0, 4'd3);
    gap_max   = 3;
    stall_pct = 30;
    send_item(CMD_PUSH,    3'd0, {SORT_KEY_W{1'b1}}, {TAG_W{1'b1}});
    send_item(CMD_PUSH,    3'd1, '0, '0);
    send_item(CMD_PUSH,    3'd2, '0, 32'd1);
    send_item(CMD_PUSH,    3'd0, 64'd5, 32'hA5A5_A5A5);
    send_item(CMD_PUSH,    3'd7, 64'd9, 32'h5A5A_5A5A);
    send_item(CMD_EXHAUST, 3'd0, '0, '0);
    send_item(CMD_EXHAUST, 3'd1, '0, '0);
    send_item(CMD_EXHAUST, 3'd2, '0, '0);
    send_item(CMD_EXHAUST, 3'd0, '0, '0);
    send_item(CMD_PUSH,    3'd1, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF);
    settle();
  endtask

  // Run count of zero acts as one, above the run total acts as the total
  task automatic test_run_count_limits();
    int i;
    write_config(1'b1, 4'd0);
    send_item(CMD_PUSH,    3'd0, 64'h8000_0000_0000_0000, 32'h1);
    send_item(CMD_PUSH,    3'd1, 64'd3, 32'h2);
    send_item(CMD_EXHAUST, 3'd0, '0, '0);
    send_item(CMD_PUSH,    3'd0, {SORT_KEY_W{1'b1}}, 32'h3);
    settle();
    write_config(1'b1, 4'd12);
    for (i = 0; i < RUN_COUNT; i++)
      send_item(CMD_PUSH, RUN_W'(i), (i == 3 || i == 6) ? {SORT_KEY_W{1'b1}}
                                                        : SORT_KEY_W'(i * 7), 32'(i));
    settle();
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_holdoff();
    int i;
    write_config(1'b0, 4'd4);
    gap_max   = 0;
    stall_pct = 0;
    hold_asked <= hold_asked + 1;
    for (i = 0; i < 60; i++) random_item();
    settle();
  endtask

  task automatic test_random_merges();
    int p;
    int i;
    logic desc;
    logic [CFG_DATA_W-1:0] runs;
    for (p = 0; p < 7; p++) begin
      case (p)
        0:       begin desc = 1'b0; runs = 4'd8; gap_max = 0; stall_pct = 0;  end
        1:       begin desc = 1'b1; runs = 4'd1; gap_max = 4; stall_pct = 40; end
        2:       begin desc = 1'b0; runs = 4'd2; gap_max = 8; stall_pct = 70; end
        3:       begin desc = 1'b1; runs = 4'd5; gap_max = 2; stall_pct = 20; end
        4:       begin desc = 1'b1; runs = 4'd8; gap_max = 6; stall_pct = 50; end
        5:       begin desc = 1'b0; runs = 4'd3; gap_max = 0; stall_pct = 0;  end
        default: begin desc = 1'b0; runs = 4'd6; gap_max = 5; stall_pct = 60; end
      endcase
      write_config(desc, runs);
      for (i = 0; i < 200; i++) random_item();
      settle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_ascending_merge();
    test_run_count_limits();
    test_output_holdoff();
    test_random_merges();
    settle();
    if (mismatches == 0 && expected_records.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
